[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the rotary encoder decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every clock edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expr must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/rebd_pkg.sv]
// Types and constants of the rotary encoder and button decoder
`timescale 1ns / 1ps
package rebd_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned MsRegW = 16;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned InTdataW = 40;
    localparam int unsigned OutTdataW = 8;

    // phase pair codes, bit 0 clock phase, bit 1 data phase
    localparam logic [1:0] PH_BOTH_LOW = 2'b00;
    localparam logic [1:0] PH_CLK_HIGH = 2'b01;
    localparam logic [1:0] PH_DAT_HIGH = 2'b10;
    localparam logic [1:0] PH_BOTH_HIGH = 2'b11;

    // configuration register indexes
    localparam logic [CfgAddrW-1:0] REG_SWAP_PHASES = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_FAST_TURN_MS = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_DEBOUNCE_MS = 2'd2;
    localparam logic [CfgAddrW-1:0] REG_HOLD_MS = 2'd3;

    localparam logic [MsRegW-1:0] FAST_TURN_MS_RST = 16'd100;
    localparam logic [MsRegW-1:0] DEBOUNCE_MS_RST = 16'd80;
    localparam logic [MsRegW-1:0] HOLD_MS_RST = 16'd700;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_RIGHT      = 3'd1,
        EV_LEFT       = 3'd2,
        EV_RIGHT_HELD = 3'd3,
        EV_LEFT_HELD  = 3'd4,
        EV_CLICK      = 3'd5,
        EV_LONG_HOLD  = 3'd6
    } event_code_t;

    typedef struct packed {
        logic              swap_phases;
        logic [MsRegW-1:0] fast_turn_ms;
        logic [MsRegW-1:0] button_debounce_ms;
        logic [MsRegW-1:0] button_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic             clear_event;
        logic [TimeW-1:0] now_ms;
        logic             hold_mode;
        logic             button_level;
        logic             phase_b;
        logic             phase_a;
    } in_item_t;

    typedef struct packed {
        logic       is_turning;
        logic       fast_turn;
        logic [2:0] event_code;
    } out_item_t;

endpackage

[rtl/rotary_encoder_button_decoder_top.sv]
// Top level of the rotary encoder and push button decoder
`timescale 1ns / 1ps
// Takes one poll word per cycle while m_tready does not stall it and returns one result
// word per poll: each accepted poll is held in the input register and decoded
// combinationally into the result register. Throughput is one word per clock when not
// stalled; s_tready follows m_tready combinationally through both registers.
// Configuration writes are always ready and take effect on the next poll; the four
// registers reset to swap 0, fast turn 100 ms, debounce 80 ms and hold 700 ms.
module rotary_encoder_button_decoder_top
    import rebd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] phase_a, [1] phase_b, [2] button_level, [3] hold_mode,
    // [35:4] now_ms, [36] clear_event, [39:37] unused
    input  logic [InTdataW-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [2:0] event_code, [3] fast_turn, [4] is_turning, [7:5] zero
    output logic [OutTdataW-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgAddrW-1:0]  cfg_addr,
    input  logic [MsRegW-1:0]    cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_ready;
    logic      step;
    out_item_t result;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_SWAP_PHASES:  cfg_next.swap_phases        = cfg_data[0];
                REG_FAST_TURN_MS: cfg_next.fast_turn_ms       = cfg_data;
                REG_DEBOUNCE_MS:  cfg_next.button_debounce_ms = cfg_data;
                REG_HOLD_MS:      cfg_next.button_hold_ms     = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swap_phases        <= 1'b0;
            cfg_reg.fast_turn_ms       <= FAST_TURN_MS_RST;
            cfg_reg.button_debounce_ms <= DEBOUNCE_MS_RST;
            cfg_reg.button_hold_ms     <= HOLD_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // advance the poll into decode whenever the result register can take it
    assign step     = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_tdata[$bits(in_item_t)-1:0];
        end
    end

    rebd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    rebd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_data  (result),
        .load_ready (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[rtl/rebd_core.sv]
// Per-poll decode of encoder detents and button events, with the decoder state
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rebd_core
    import rebd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [TimeW-1:0] timer_reg, timer_next;
    logic [1:0]       prev_reg, prev_next;
    logic             armed_reg, armed_next;
    event_code_t      latched_reg, latched_next;
    logic             fast_reg, fast_next;
    logic             turned_reg, turned_next;
    logic             bsample_reg, bsample_next;
    logic             press_reg, press_next;
    logic             hold_reg, hold_next;

    logic             detent;

    always_comb begin
        logic [TimeW-1:0] elapsed;
        logic [TimeW-1:0] fast_lim;
        logic [TimeW-1:0] deb_lim;
        logic [TimeW-1:0] hold_lim;
        logic [1:0]       phases;
        logic             held;
        logic             press_acc;
        event_code_t      ev;

        elapsed  = item.now_ms - timer_reg;
        fast_lim = {{(TimeW-MsRegW){1'b0}}, cfg.fast_turn_ms};
        deb_lim  = {{(TimeW-MsRegW){1'b0}}, cfg.button_debounce_ms};
        hold_lim = {{(TimeW-MsRegW){1'b0}}, cfg.button_hold_ms};
        phases   = cfg.swap_phases ? {item.phase_a, item.phase_b}
                                   : {item.phase_b, item.phase_a};
        held     = !bsample_reg || item.hold_mode;

        ev          = latched_reg;
        fast_next   = fast_reg;
        timer_next  = timer_reg;
        turned_next = turned_reg;
        armed_next  = armed_reg;
        press_next  = press_reg;
        hold_next   = hold_reg;

        detent = armed_reg && (phases == PH_BOTH_HIGH);
        if (detent) begin
            // direction comes from the pair seen just before the return to 11
            if (prev_reg == PH_DAT_HIGH) begin
                ev = held ? EV_RIGHT_HELD : EV_RIGHT;
            end else if (prev_reg == PH_CLK_HIGH) begin
                ev = held ? EV_LEFT_HELD : EV_LEFT;
            end
            fast_next   = (ev != EV_NONE) && (elapsed < fast_lim);
            timer_next  = item.now_ms;
            turned_next = 1'b1;
            armed_next  = 1'b0;
        end
        if (phases == PH_BOTH_LOW) begin
            armed_next = 1'b1;
        end
        prev_next    = phases;
        bsample_next = item.button_level;

        press_acc = !item.button_level && !press_reg && (elapsed > deb_lim);
        if (press_acc) begin
            timer_next  = item.now_ms;
            elapsed     = '0;
            press_next  = 1'b1;
            turned_next = 1'b0;
            hold_next   = 1'b0;
        end
        if (!item.button_level && press_next && !hold_next) begin
            if ((ev != EV_NONE) && (elapsed < hold_lim)) begin
                hold_next = 1'b1;
            end
            if ((ev == EV_NONE) && (elapsed > hold_lim)) begin
                ev        = EV_LONG_HOLD;
                hold_next = 1'b1;
            end
        end
        if (item.button_level && press_next) begin
            if (!hold_next && (elapsed > deb_lim) && !turned_next) begin
                ev = EV_CLICK;
            end
            timer_next = item.now_ms;
            press_next = 1'b0;
        end

        result.event_code = ev;
        result.fast_turn  = fast_next;
        unique case (ev)
            EV_RIGHT, EV_LEFT, EV_RIGHT_HELD, EV_LEFT_HELD: result.is_turning = 1'b1;
            default:                                        result.is_turning = 1'b0;
        endcase
        // drop the latched event when the poll sets clear_event
        latched_next = item.clear_event ? EV_NONE : ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg   <= '0;
            prev_reg    <= PH_BOTH_LOW;
            armed_reg   <= 1'b0;
            latched_reg <= EV_NONE;
            fast_reg    <= 1'b0;
            turned_reg  <= 1'b0;
            bsample_reg <= 1'b1;
            press_reg   <= 1'b0;
            hold_reg    <= 1'b0;
        end else if (step) begin
            timer_reg   <= timer_next;
            prev_reg    <= prev_next;
            armed_reg   <= armed_next;
            latched_reg <= latched_next;
            fast_reg    <= fast_next;
            turned_reg  <= turned_next;
            bsample_reg <= bsample_next;
            press_reg   <= press_next;
            hold_reg    <= hold_next;
        end
    end

    `ASSERT_AT(a_clear_empties, aclk, aresetn, step && item.clear_event |=> latched_reg == EV_NONE)
    `ASSERT_AT(a_detent_restarts_timer, aclk, aresetn, step && detent |=> timer_reg == $past(item.now_ms))
    `ASSERT_AT(a_idle_keeps_state, aclk, aresetn, !step |=> $stable(latched_reg) && $stable(timer_reg))
    `ASSERT_NEVER(a_press_needs_low, aclk, aresetn, press_reg && bsample_reg)

endmodule

[rtl/rebd_out_stage.sv]
// Result register between the decoder and the result stream
`timescale 1ns / 1ps
module rebd_out_stage
    import rebd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_valid,
    input  out_item_t            load_data,
    output logic                 load_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign load_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load_ready) begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the word while the sink stalls
    always_ff @(posedge aclk) begin
        if (load_ready && load_valid) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OutTdataW-$bits(out_item_t)){1'b0}}, data_reg};

endmodule
